// ===== hdl/assert_macros.svh =====
// Assertion macros used by the port-level checker.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, reset masks the check.
`define ILHA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never hold at a clock edge.
`define ILHA_NEVER(lbl, cond, msg) \
  `ILHA_ASSERT(lbl, !(cond), msg)

`endif

// ===== hdl/ilha_pkg.sv =====
// Package of the heap allocator: sizes, codes, state type, memory request type.
// No dependencies.
package ilha_pkg;

  localparam int HEAP_BYTES  = 65536;
  localparam int CHUNK_BYTES = 4096;
  localparam int NWORDS      = HEAP_BYTES / 4;
  localparam int WIDX_W      = $clog2(NWORDS);
  localparam int ADDR_W      = $clog2(HEAP_BYTES) + 1;
  localparam int DATA_W      = 16;
  localparam int WALK_LIMIT  = HEAP_BYTES / 8 + 4;
  localparam int CNT_W       = $clog2(WALK_LIMIT + 1);
  localparam int INIT_SIZE   = ((CHUNK_BYTES / 4) + ((CHUNK_BYTES / 4) % 2)) * 4;
  localparam int INIT_BRK    = 16 + INIT_SIZE;
  localparam int FIRST_BP    = 8;

  // Operation and status codes
  localparam logic       OP_ALLOC  = 1'b0;
  localparam logic       OP_FREE   = 1'b1;
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_ZERO   = 2'd1;
  localparam logic [1:0] ST_OOM    = 2'd2;

  typedef enum logic [4:0] {
    S_INIT_PRO0, S_INIT_PRO1, S_INIT_HDR, S_INIT_FTR, S_INIT_EPI,
    S_IDLE, S_FREE_RD, S_FREE_FTR, S_MRG_PREV, S_MRG_NEXT, S_MRG_W2,
    S_SRCH, S_SRCH_WRAP, S_GROW, S_GROW_FTR, S_GROW_EPI,
    S_PUT, S_PUT_FTR, S_PUT_NHDR, S_PUT_NFTR, S_DONE
  } state_e;

  typedef struct packed {
    logic              we;
    logic [WIDX_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic [WIDX_W-1:0] raddr;
  } mem_req_t;

  function automatic logic [WIDX_W-1:0] word_idx(input logic [ADDR_W-1:0] a);
    return a[WIDX_W+1:2];
  endfunction

endpackage

// ===== hdl/ilha_req_if.sv =====
// Request channel of the heap allocator: valid/ready plus request fields.
// Depends on ilha_pkg.
interface ilha_req_if;
  import ilha_pkg::*;
  logic              valid;
  logic              ready;
  logic              op;
  logic [DATA_W-1:0] req_bytes;
  logic [DATA_W-1:0] block_addr;
  modport source (output valid, op, req_bytes, block_addr, input ready);
  modport sink   (input valid, op, req_bytes, block_addr, output ready);
endinterface

// ===== hdl/ilha_rsp_if.sv =====
// Response channel of the heap allocator: valid/ready plus result fields.
// Depends on ilha_pkg.
interface ilha_rsp_if;
  import ilha_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] result_addr;
  logic [1:0]        status;
  modport source (output valid, result_addr, status, input ready);
  modport sink   (input valid, result_addr, status, output ready);
endinterface

// ===== hdl/ilha_tag_mem.sv =====
// Boundary-tag word memory: one write and one registered read per cycle.
// Depends on ilha_pkg; a same-cycle write to the read word is forwarded.
module ilha_tag_mem (
  input  logic                       clk_i,
  input  ilha_pkg::mem_req_t         req_i,
  output logic [ilha_pkg::DATA_W-1:0] rdata_o
);
  import ilha_pkg::*;

  logic [DATA_W-1:0] mem [NWORDS];
  logic [DATA_W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) mem[req_i.waddr] <= req_i.wdata;
  end

  // read port with write forwarding
  always_ff @(posedge clk_i) begin
    if (req_i.we && (req_i.waddr == req_i.raddr)) rdata_q <= req_i.wdata;
    else rdata_q <= mem[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/implicit_list_heap_allocator_unit.sv =====
// Heap allocator, next-fit over boundary tags in a tag memory with one write and one read port.
// Free: read header, clear marks, read neighbours, merge; null free, zero size: to S_DONE.
// Allocate: walk headers, write tags, and the remainder's on a split; may wrap, then grow.
// One transaction at a time; the next request is taken from the cycle in which the
// result appears, while it waits; an unread result holds the next one in S_DONE.
// Reset: S_INIT_* write the initial prologue, free chunk and epilogue; no request taken then.
module implicit_list_heap_allocator_unit (
  input logic         clk_i,
  input logic         rst_ni,
  ilha_req_if.sink    req_i,
  ilha_rsp_if.source  rsp_o
);
  import ilha_pkg::*;

  localparam logic [ADDR_W-1:0] A4     = ADDR_W'(4);
  localparam logic [ADDR_W-1:0] A8     = ADDR_W'(8);
  localparam logic [ADDR_W-1:0] A16    = ADDR_W'(16);
  localparam logic [ADDR_W-1:0] CHUNK_A = ADDR_W'(CHUNK_BYTES);
  localparam logic [ADDR_W:0]   HEAP_X = (ADDR_W+1)'(HEAP_BYTES);
  localparam logic [DATA_W-1:0] ALLOC_TAG = DATA_W'(1);

  state_e             state_q, state_d;
  logic               op_q, op_d;
  logic [ADDR_W-1:0]  bp_q, bp_d, size_q, size_d, asize_q, asize_d;
  logic [ADDR_W-1:0]  cur_q, cur_d, psize_q, psize_d, w2_q, w2_d;
  logic [ADDR_W-1:0]  brk_q, brk_d;
  logic [DATA_W-1:0]  rover_q, rover_d, start_q, start_d;
  logic               pa_q, pa_d, phase_q, phase_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [DATA_W-1:0]  res_addr_q, res_addr_d, out_addr_q, out_addr_d;
  logic [1:0]         res_st_q, res_st_d, out_st_q, out_st_d;
  logic               out_vld_q, out_vld_d;

  mem_req_t           mreq;
  logic [DATA_W-1:0]  rdata;
  logic [ADDR_W-1:0]  hsz, asz_in, ext, gsize, nxt;
  logic [ADDR_W:0]    brk_sum;
  logic               split;

  ilha_tag_mem u_mem (.clk_i(clk_i), .req_i(mreq), .rdata_o(rdata));

  // decoded sizes
  assign hsz     = {1'b0, rdata[DATA_W-1:3], 3'b000};
  assign asz_in  = (req_i.req_bytes <= DATA_W'(8)) ? A16 :
                   (({1'b0, req_i.req_bytes} + ADDR_W'(15)) & ~ADDR_W'(7));
  assign split   = (size_q >= asize_q) && ((size_q - asize_q) >= A16);
  assign ext     = (asize_q > CHUNK_A) ? asize_q : CHUNK_A;
  assign gsize   = {ext[ADDR_W-1:3], 3'b000} + (ext[2] ? A8 : '0);
  assign brk_sum = {1'b0, brk_q} + {1'b0, gsize};
  assign nxt     = cur_q + hsz;

  assign req_i.ready       = (state_q == S_IDLE);
  assign rsp_o.valid       = out_vld_q;
  assign rsp_o.result_addr = out_addr_q;
  assign rsp_o.status      = out_st_q;

  // registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_INIT_PRO0;
      rover_q   <= DATA_W'(FIRST_BP);
      brk_q     <= ADDR_W'(INIT_BRK);
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rover_q   <= rover_d;
      brk_q     <= brk_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;  bp_q <= bp_d;  size_q <= size_d;  asize_q <= asize_d;
    cur_q <= cur_d;  psize_q <= psize_d;  w2_q <= w2_d;  start_q <= start_d;
    pa_q <= pa_d;  phase_q <= phase_d;  cnt_q <= cnt_d;
    res_addr_q <= res_addr_d;  res_st_q <= res_st_d;
    out_addr_q <= out_addr_d;  out_st_q <= out_st_d;
  end

  // sequencer
  always_comb begin
    state_d = state_q;  op_d = op_q;  bp_d = bp_q;  size_d = size_q;
    asize_d = asize_q;  cur_d = cur_q;  psize_d = psize_q;  w2_d = w2_q;
    brk_d = brk_q;  rover_d = rover_q;  start_d = start_q;  pa_d = pa_q;
    phase_d = phase_q;  cnt_d = cnt_q;
    res_addr_d = res_addr_q;  res_st_d = res_st_q;
    out_addr_d = out_addr_q;  out_st_d = out_st_q;
    out_vld_d = out_vld_q && !rsp_o.ready;
    mreq = '0;

    unique case (state_q)
      S_INIT_PRO0: begin
        mreq.we = 1'b1;  mreq.waddr = word_idx(A4);
        mreq.wdata = DATA_W'(9);  state_d = S_INIT_PRO1;
      end
      S_INIT_PRO1: begin
        mreq.we = 1'b1;  mreq.waddr = word_idx(A8);
        mreq.wdata = DATA_W'(9);  state_d = S_INIT_HDR;
      end
      S_INIT_HDR: begin
        mreq.we = 1'b1;  mreq.waddr = word_idx(ADDR_W'(12));
        mreq.wdata = DATA_W'(INIT_SIZE);  state_d = S_INIT_FTR;
      end
      S_INIT_FTR: begin
        mreq.we = 1'b1;  mreq.waddr = word_idx(ADDR_W'(INIT_BRK - 8));
        mreq.wdata = DATA_W'(INIT_SIZE);  state_d = S_INIT_EPI;
      end
      S_INIT_EPI: begin
        mreq.we = 1'b1;  mreq.waddr = word_idx(ADDR_W'(INIT_BRK - 4));
        mreq.wdata = ALLOC_TAG;  state_d = S_IDLE;
      end

      S_IDLE: begin
        if (req_i.valid) begin
          op_d = req_i.op;
          res_addr_d = '0;
          res_st_d = ST_OK;
          if (req_i.op == OP_FREE) begin
            bp_d = {1'b0, req_i.block_addr};
            mreq.raddr = word_idx({1'b0, req_i.block_addr} - A4);
            state_d = (req_i.block_addr == '0) ? S_DONE : S_FREE_RD;
          end else if (req_i.req_bytes == '0) begin
            res_st_d = ST_ZERO;
            state_d = S_DONE;
          end else begin
            asize_d = asz_in;
            start_d = rover_q;
            cur_d = {1'b0, rover_q};
            phase_d = 1'b0;
            cnt_d = '0;
            mreq.raddr = word_idx({1'b0, rover_q} - A4);
            state_d = S_SRCH;
          end
        end
      end

      // free: clear the allocated mark in header and footer
      S_FREE_RD: begin
        size_d = hsz;
        mreq.we = 1'b1;  mreq.waddr = word_idx(bp_q - A4);
        mreq.wdata = hsz[DATA_W-1:0];
        state_d = S_FREE_FTR;
      end
      S_FREE_FTR: begin
        mreq.we = 1'b1;  mreq.waddr = word_idx(bp_q + size_q - A8);
        mreq.wdata = size_q[DATA_W-1:0];
        mreq.raddr = word_idx(bp_q - A8);
        state_d = S_MRG_PREV;
      end

      // coalescing: previous footer, then next header
      S_MRG_PREV: begin
        pa_d = rdata[0];
        psize_d = hsz;
        mreq.raddr = word_idx(bp_q + size_q - A4);
        state_d = S_MRG_NEXT;
      end
      S_MRG_NEXT: begin
        mreq.we = 1'b1;
        if (pa_q && rdata[0]) begin
          mreq.we = 1'b0;
          state_d = (op_q == OP_ALLOC) ? S_PUT : S_DONE;
        end else if (pa_q) begin
          size_d = size_q + hsz;
          mreq.waddr = word_idx(bp_q - A4);
          mreq.wdata = size_d[DATA_W-1:0];
          w2_d = bp_q + size_d - A8;
          state_d = S_MRG_W2;
        end else if (rdata[0]) begin
          size_d = size_q + psize_q;
          mreq.waddr = word_idx(bp_q + size_q - A8);
          mreq.wdata = size_d[DATA_W-1:0];
          w2_d = bp_q - psize_q - A4;
          bp_d = bp_q - psize_q;
          state_d = S_MRG_W2;
        end else begin
          size_d = size_q + psize_q + hsz;
          mreq.waddr = word_idx(bp_q - psize_q - A4);
          mreq.wdata = size_d[DATA_W-1:0];
          w2_d = bp_q + size_q + hsz - A8;
          bp_d = bp_q - psize_q;
          state_d = S_MRG_W2;
        end
      end
      S_MRG_W2: begin
        mreq.we = 1'b1;  mreq.waddr = word_idx(w2_q);
        mreq.wdata = size_q[DATA_W-1:0];
        // rover inside the merged block moves to its start
        if (({1'b0, rover_q} >= bp_q) && ({1'b0, rover_q} < bp_q + size_q))
          rover_d = bp_q[DATA_W-1:0];
        state_d = (op_q == OP_ALLOC) ? S_PUT : S_DONE;
      end

      // next-fit walk, one header per cycle
      S_SRCH: begin
        if ((cnt_q >= CNT_W'(WALK_LIMIT)) || (hsz == '0)) begin
          if (!phase_q) begin
            phase_d = 1'b1;
            cnt_d = '0;
            cur_d = ADDR_W'(FIRST_BP);
            state_d = S_SRCH_WRAP;
          end else begin
            state_d = S_GROW;
          end
        end else if (!rdata[0] && (asize_q <= hsz)) begin
          rover_d = cur_q[DATA_W-1:0];
          bp_d = cur_q;
          size_d = hsz;
          state_d = S_PUT;
        end else if (phase_q && (nxt >= {1'b0, start_q})) begin
          state_d = S_GROW;
        end else begin
          cur_d = nxt;
          cnt_d = cnt_q + 1'b1;
          mreq.raddr = word_idx(nxt - A4);
        end
      end
      S_SRCH_WRAP: begin
        mreq.raddr = word_idx(cur_q - A4);
        state_d = (cur_q < {1'b0, start_q}) ? S_SRCH : S_GROW;
      end

      // extend the break and lay down a new free block, or report out of memory
      S_GROW: begin
        if (brk_sum > HEAP_X) begin
          res_st_d = ST_OOM;
          state_d = S_DONE;
        end else begin
          bp_d = brk_q;
          size_d = gsize;
          brk_d = brk_sum[ADDR_W-1:0];
          mreq.we = 1'b1;  mreq.waddr = word_idx(brk_q - A4);
          mreq.wdata = gsize[DATA_W-1:0];
          state_d = S_GROW_FTR;
        end
      end
      S_GROW_FTR: begin
        mreq.we = 1'b1;  mreq.waddr = word_idx(bp_q + size_q - A8);
        mreq.wdata = size_q[DATA_W-1:0];
        state_d = S_GROW_EPI;
      end
      S_GROW_EPI: begin
        mreq.we = 1'b1;  mreq.waddr = word_idx(bp_q + size_q - A4);
        mreq.wdata = ALLOC_TAG;
        mreq.raddr = word_idx(bp_q - A8);
        state_d = S_MRG_PREV;
      end

      // placement with optional split
      S_PUT: begin
        mreq.we = 1'b1;  mreq.waddr = word_idx(bp_q - A4);
        mreq.wdata = split ? (asize_q[DATA_W-1:0] | ALLOC_TAG)
                           : (size_q[DATA_W-1:0] | ALLOC_TAG);
        res_addr_d = bp_q[DATA_W-1:0];
        state_d = S_PUT_FTR;
      end
      S_PUT_FTR: begin
        mreq.we = 1'b1;
        mreq.waddr = word_idx(bp_q + (split ? asize_q : size_q) - A8);
        mreq.wdata = split ? (asize_q[DATA_W-1:0] | ALLOC_TAG)
                           : (size_q[DATA_W-1:0] | ALLOC_TAG);
        state_d = split ? S_PUT_NHDR : S_DONE;
      end
      S_PUT_NHDR: begin
        mreq.we = 1'b1;  mreq.waddr = word_idx(bp_q + asize_q - A4);
        mreq.wdata = DATA_W'(size_q - asize_q);
        state_d = S_PUT_NFTR;
      end
      S_PUT_NFTR: begin
        mreq.we = 1'b1;  mreq.waddr = word_idx(bp_q + size_q - A8);
        mreq.wdata = DATA_W'(size_q - asize_q);
        state_d = S_DONE;
      end

      // hand the result to the output register once it is free
      S_DONE: begin
        if (!out_vld_q || rsp_o.ready) begin
          out_vld_d = 1'b1;
          out_addr_d = res_addr_q;
          out_st_d = res_st_q;
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ===== hdl/ilha_checker.sv =====
// Port-level checker for the heap allocator and its bind to the top level.
// Depends on ilha_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ilha_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        req_valid_i,
  input logic                        req_ready_i,
  input logic                        rsp_valid_i,
  input logic                        rsp_ready_i,
  input logic [ilha_pkg::DATA_W-1:0] result_addr_i,
  input logic [1:0]                  status_i
);
  import ilha_pkg::*;

  // one transaction in flight: ready drops right after an accept
  `ILHA_ASSERT(a_one_at_a_time, (req_valid_i && req_ready_i) |=> !req_ready_i, "ready after accept")
  // status code range
  `ILHA_NEVER(a_status_range, rsp_valid_i && (status_i != ST_OK) && (status_i != ST_ZERO) && (status_i != ST_OOM), "bad status")
  // failures carry a null address
  `ILHA_NEVER(a_fail_null, rsp_valid_i && (status_i != ST_OK) && (result_addr_i != '0), "fail with address")
  // payload addresses are 8-byte aligned
  `ILHA_NEVER(a_aligned, rsp_valid_i && (result_addr_i[2:0] != 3'b000), "misaligned address")
  // stalled result holds
  `ILHA_ASSERT(a_rsp_hold, (rsp_valid_i && !rsp_ready_i) |=> (rsp_valid_i && $stable(result_addr_i) && $stable(status_i)), "result dropped")

endmodule

bind implicit_list_heap_allocator_unit ilha_checker u_ilha_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .result_addr_i (rsp_o.result_addr),
  .status_i      (rsp_o.status)
);

// ===== verif/ilha_checker.sv =====
// Checker for the heap allocator: watches both channels, predicts each response, compares.
// Depends on ilha_pkg and the ilha_req_if / ilha_rsp_if interfaces.
`timescale 1ns / 100ps

module ilha_tb_checker
  import ilha_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  ilha_req_if   req_i,
  ilha_rsp_if   rsp_i,
  output int    fail_count_o,
  output int    pending_o
);

  typedef struct {
    logic [DATA_W-1:0] addr;
    logic [1:0]        status;
  } alloc_result_t;

  // Shadow heap: tag words, roving position and break
  int unsigned   heap_tags [NWORDS];
  int unsigned   rover;
  int unsigned   brk;
  alloc_result_t result_q[$];
  int            mismatches;

  function automatic int unsigned tag_rd(int unsigned a);
    return heap_tags[(a >> 2) % NWORDS];
  endfunction

  function automatic void tag_wr(int unsigned a, int unsigned v);
    heap_tags[(a >> 2) % NWORDS] = v;
  endfunction

  function automatic int unsigned blk_size(int unsigned a);
    return tag_rd(a) & ~32'd7;
  endfunction

  function automatic int unsigned blk_used(int unsigned a);
    return tag_rd(a) & 32'd1;
  endfunction

  function automatic int unsigned footer_of(int unsigned bp);
    return bp + blk_size(bp - 4) - 8;
  endfunction

  function automatic int unsigned next_of(int unsigned bp);
    return bp + blk_size(bp - 4);
  endfunction

  function automatic int unsigned prev_of(int unsigned bp);
    return bp - blk_size(bp - 8);
  endfunction

  // Four-case boundary-tag coalescing; pulls the rover back if swallowed
  function automatic int unsigned coalesce(int unsigned bp);
    int unsigned prev_used, next_used, size;
    prev_used = blk_used(footer_of(prev_of(bp)));
    next_used = blk_used(next_of(bp) - 4);
    size      = blk_size(bp - 4);
    if (prev_used && next_used) return bp;
    if (prev_used) begin
      size += blk_size(next_of(bp) - 4);
      tag_wr(bp - 4, size);
      tag_wr(footer_of(bp), size);
    end else if (next_used) begin
      size += blk_size(prev_of(bp) - 4);
      tag_wr(footer_of(bp), size);
      tag_wr(prev_of(bp) - 4, size);
      bp = prev_of(bp);
    end else begin
      size += blk_size(prev_of(bp) - 4) + blk_size(footer_of(next_of(bp)));
      tag_wr(prev_of(bp) - 4, size);
      tag_wr(footer_of(next_of(bp)), size);
      bp = prev_of(bp);
    end
    if (rover >= bp && rover < next_of(bp)) rover = bp;
    return bp;
  endfunction

  function automatic int unsigned grow_break(int unsigned bytes);
    int unsigned words, size, bp;
    words = bytes >> 2;
    size  = (words + (words & 1)) * 4;
    bp    = brk;
    if (brk > HEAP_BYTES || size > HEAP_BYTES - brk) return 0;
    brk += size;
    tag_wr(bp - 4, size);
    tag_wr(footer_of(bp), size);
    tag_wr(next_of(bp) - 4, 1);
    return coalesce(bp);
  endfunction

  function automatic bit fits(int unsigned bp, int unsigned asize);
    return !blk_used(bp - 4) && asize <= blk_size(bp - 4);
  endfunction

  // Next-fit from the rover, then one wrapped pass from the first block
  function automatic int unsigned next_fit_walk(int unsigned asize);
    int unsigned start, cur, n;
    start = rover;
    cur = start;
    for (n = 0; n < WALK_LIMIT && blk_size(cur - 4) > 0; n++) begin
      if (fits(cur, asize)) begin
        rover = cur;
        return cur;
      end
      cur = next_of(cur);
    end
    cur = FIRST_BP;
    for (n = 0; n < WALK_LIMIT && cur < start && blk_size(cur - 4) > 0; n++) begin
      if (fits(cur, asize)) begin
        rover = cur;
        return cur;
      end
      cur = next_of(cur);
    end
    rover = start;
    return 0;
  endfunction

  function automatic void place(int unsigned bp, int unsigned asize);
    int unsigned csize;
    csize = blk_size(bp - 4);
    if (csize >= asize && csize - asize >= 16) begin
      tag_wr(bp - 4, asize | 1);
      tag_wr(footer_of(bp), asize | 1);
      bp = next_of(bp);
      tag_wr(bp - 4, csize - asize);
      tag_wr(footer_of(bp), csize - asize);
    end else begin
      tag_wr(bp - 4, csize | 1);
      tag_wr(footer_of(bp), csize | 1);
    end
  endfunction

  function automatic alloc_result_t apply_request(logic op, int unsigned req, int unsigned addr);
    alloc_result_t r;
    int unsigned   asize, bp, size;
    r.addr   = '0;
    r.status = ST_OK;
    if (op == OP_FREE) begin
      if (addr != 0) begin
        size = blk_size(addr - 4);
        tag_wr(addr - 4, size);
        tag_wr(footer_of(addr), size);
        void'(coalesce(addr));
      end
      return r;
    end
    if (req == 0) begin
      r.status = ST_ZERO;
      return r;
    end
    asize = (req <= 8) ? 16 : 8 * ((req + 15) / 8);
    bp = next_fit_walk(asize);
    if (bp == 0) begin
      bp = grow_break((asize > CHUNK_BYTES) ? asize : CHUNK_BYTES);
      if (bp == 0) begin
        r.status = ST_OOM;
        return r;
      end
    end
    place(bp, asize);
    r.addr = bp[DATA_W-1:0];
    return r;
  endfunction

  // Initial layout: prologue, one free chunk, epilogue
  initial begin
    foreach (heap_tags[i]) heap_tags[i] = 0;
    tag_wr(4, 9);
    tag_wr(8, 9);
    tag_wr(12, 1);
    brk   = 16;
    rover = FIRST_BP;
    void'(grow_break(CHUNK_BYTES));
    mismatches = 0;
  end

  // Predict on request transactions, compare on response transactions
  always @(posedge clk_i) begin
    alloc_result_t exp_r;
    if (rst_ni) begin
      if (req_i.valid && req_i.ready)
        result_q.push_back(apply_request(req_i.op, req_i.req_bytes, req_i.block_addr));
      if (rsp_i.valid && rsp_i.ready) begin
        if (result_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected response: addr %0d status %0d", rsp_i.result_addr,
                     rsp_i.status);
        end else begin
          exp_r = result_q.pop_front();
          if (rsp_i.result_addr !== exp_r.addr || rsp_i.status !== exp_r.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected addr %0d status %0d, got addr %0d status %0d",
                       exp_r.addr, exp_r.status, rsp_i.result_addr, rsp_i.status);
          end
        end
      end
    end
  end

  assign fail_count_o = mismatches;
  assign pending_o    = result_q.size();

endmodule

// ===== verif/testbench.sv =====
// Top of the heap allocator testbench: clock, reset, request stimulus, response stalls, verdict.
// Depends on ilha_pkg, the channel interfaces, the allocator and ilha_tb_checker.
`timescale 1ns / 100ps

module testbench;
  import ilha_pkg::*;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   idle_pct;
  int   stall_pct;
  logic [DATA_W-1:0] live_blocks[$];

  ilha_req_if req_if ();
  ilha_rsp_if rsp_if ();

  implicit_list_heap_allocator_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  ilha_tb_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_if),
    .rsp_i        (rsp_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Response stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Track live allocations from returned addresses
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready && rsp_if.status == ST_OK
        && rsp_if.result_addr != 0)
      live_blocks.push_back(rsp_if.result_addr);
  end

  // One request transaction; called right after a rising edge
  task automatic send(logic op, logic [DATA_W-1:0] bytes, logic [DATA_W-1:0] addr);
    if ($urandom_range(99) < idle_pct) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.op         <= op;
    req_if.req_bytes  <= bytes;
    req_if.block_addr <= addr;
    @(negedge clk_i);
    while (!req_if.ready) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic alloc_bytes(logic [DATA_W-1:0] bytes);
    send(OP_ALLOC, bytes, DATA_W'($urandom));
  endtask

  task automatic free_live(int idx);
    logic [DATA_W-1:0] a;
    a = live_blocks[idx];
    live_blocks.delete(idx);
    send(OP_FREE, DATA_W'($urandom), a);
  endtask

  // Sampled at the falling edge so the last accept is already counted
  task automatic drain();
    req_if.valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  function automatic logic [DATA_W-1:0] pick_size();
    int r;
    r = $urandom_range(99);
    if (r < 3)  return DATA_W'($urandom_range(65535, 20000));
    if (r < 13) return DATA_W'($urandom_range(5000, 1000));
    if (r < 16) return '0;
    return DATA_W'($urandom_range(256, 1));
  endfunction

  initial begin
    automatic int n_items = 1450;
    req_if.valid      = 1'b0;
    req_if.op         = OP_ALLOC;
    req_if.req_bytes  = '0;
    req_if.block_addr = '0;
    idle_pct  = 0;
    stall_pct = 0;
    rst_ni    = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: size extremes, zero size, growth, out of memory, null free
    alloc_bytes(16'd0);
    alloc_bytes(16'd1);
    alloc_bytes(16'd8);
    alloc_bytes(16'd9);
    alloc_bytes(16'd24);
    alloc_bytes(16'd100);
    alloc_bytes(16'd65535);
    alloc_bytes(16'd5000);
    alloc_bytes(16'd4096);
    alloc_bytes(16'd40);
    alloc_bytes(16'd40);
    send(OP_FREE, 16'hFFFF, 16'd0);
    drain();
    // Coalescing: no free neighbor, both free, next free
    if (live_blocks.size() >= 8) begin
      free_live(1);
      free_live(2);
      free_live(1);
      free_live(3);
      free_live(2);
      free_live(0);
    end
    alloc_bytes(16'd30000);
    alloc_bytes(16'd30000);
    alloc_bytes(16'd16);
    drain();

    // Random: four phases of request idling and response stalls
    for (int i = 0; i < n_items; i++) begin
      case (i * 4 / n_items)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 50; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 50; end
        default: begin idle_pct = 7; stall_pct = 7; end
      endcase
      if (live_blocks.size() > 0 && $urandom_range(99) < 45)
        free_live($urandom_range(live_blocks.size() - 1));
      else
        alloc_bytes(pick_size());
    end
    drain();
    repeat (50) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin
    #1000000000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/ilha_pkg.sv
hdl/ilha_req_if.sv
hdl/ilha_rsp_if.sv
hdl/ilha_tag_mem.sv
hdl/implicit_list_heap_allocator_unit.sv
hdl/ilha_checker.sv
verif/ilha_checker.sv
verif/testbench.sv
